[rtl/sact_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sact_pkg
// Geometry, row layout and controller types shared by the cache tag
// controller.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_BITS   = 32;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  // usable address bits of a 32-bit word
  localparam int A_BITS    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int OFF_BITS  = floor_log2(BLOCK_BYTES);
  localparam int IDX_BITS  = floor_log2(SETS);
  localparam int TAG_BITS  = A_BITS - OFF_BITS - IDX_BITS;
  localparam int OFF_W     = (OFF_BITS > 0) ? OFF_BITS : 1;
  localparam int IDX_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int SET_DEPTH = 1 << IDX_BITS;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [31:0] ADDR_MASK = 32'((64'h1 << A_BITS) - 64'h1);
  localparam logic [31:0] OFF_MASK  = 32'((64'h1 << OFF_BITS) - 64'h1);
  localparam logic [31:0] SET_MASK  = 32'(SET_DEPTH - 1);
  localparam logic [WAY_BITS-1:0] AGE_MAX = WAY_BITS'(WAYS - 1);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                dirty;
    logic [WAY_BITS-1:0] age;
    logic [OFF_W-1:0]    offset;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] set_row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } sact_cmd_t;

endpackage
`default_nettype wire

[rtl/sact_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sact_ram
// Simple dual-port RAM, one write and one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/sact_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sact_ctrl
// Access sequencer: takes a word, waits in the lookup state for the registered
// set row, then commits the update once the result register is free.
// ----------------------------------------------------------------------------
module sact_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sact_pkg::sact_cmd_t   cmd
);
  import sact_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

[rtl/sact_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sact_dpath
// Tag row RAM, per-line valid flops, hit/fill/victim selection, age update
// and the result register.
// ----------------------------------------------------------------------------
module sact_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sact_pkg::sact_cmd_t cmd,
  input  wire logic [31:0]         address,
  input  wire logic                is_write,
  output logic                     hit,
  output logic                     evicted,
  output logic [31:0]              victim_address,
  output logic [1:0]               way_used
);
  import sact_pkg::*;

  logic [31:0]         addr_q;
  logic                wr_q;
  logic [WAYS-1:0]     valid [SET_DEPTH];

  logic [IDX_W-1:0]    in_set;
  logic [31:0]         addr_m;
  logic [TAG_BITS-1:0] tag;
  logic [IDX_W-1:0]    set_idx;
  logic [OFF_W-1:0]    off;

  set_row_t            row_rd;
  set_row_t            row_wr;
  logic [WAYS-1:0]     row_valid;

  logic                hit_c;
  logic                free_c;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] cand;
  logic                cand_dirty;
  logic [WAY_BITS-1:0] used;
  logic [31:0]         ev_addr;

  assign in_set  = IDX_W'(((address & ADDR_MASK) >> OFF_BITS) & SET_MASK);
  assign addr_m  = addr_q & ADDR_MASK;
  assign tag     = TAG_BITS'(addr_m >> (OFF_BITS + IDX_BITS));
  assign set_idx = IDX_W'((addr_m >> OFF_BITS) & SET_MASK);
  assign off     = OFF_W'(addr_m & OFF_MASK);

  sact_ram #(
    .WIDTH ($bits(set_row_t)),
    .DEPTH (SET_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_idx),
    .wdata (row_wr),
    .re    (cmd.capture),
    .raddr (in_set),
    .rdata (row_rd)
  );

  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    cand       = '0;
    cand_dirty = 1'b0;
    // lowest matching / lowest free way wins
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row_valid[i] && row_rd[i].tag == tag) begin
        hit_c   = 1'b1;
        hit_way = WAY_BITS'(i);
      end
      if (!row_valid[i]) begin
        free_c   = 1'b1;
        free_way = WAY_BITS'(i);
      end
    end
    // victim scan: older wins, dirty candidate yields only to dirty
    for (int i = 0; i < WAYS; i++) begin
      if (row_rd[cand].age <= row_rd[i].age) begin
        if (!cand_dirty) begin
          cand       = WAY_BITS'(i);
          cand_dirty = row_rd[i].dirty;
        end else if (row_rd[i].dirty) begin
          cand = WAY_BITS'(i);
        end
      end
    end
    if (hit_c) begin
      used = hit_way;
    end else if (free_c) begin
      used = free_way;
    end else begin
      used = cand;
    end
    ev_addr = ((32'(row_rd[cand].tag) << (OFF_BITS + IDX_BITS))
              | (32'(set_idx) << OFF_BITS)
              | 32'(row_rd[cand].offset)) & ADDR_MASK;

    row_wr = row_rd;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_BITS'(i) == used) begin
        row_wr[i].age = '0;
        if (hit_c) begin
          row_wr[i].dirty = row_rd[i].dirty | wr_q;
        end else begin
          row_wr[i].tag    = tag;
          row_wr[i].dirty  = wr_q;
          row_wr[i].offset = off;
        end
      end else if (row_rd[i].age < AGE_MAX) begin
        row_wr[i].age = row_rd[i].age + WAY_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q    <= address;
      wr_q      <= is_write;
      row_valid <= valid[in_set];
    end
    if (cmd.commit) begin
      hit            <= hit_c;
      evicted        <= !hit_c && !free_c;
      victim_address <= (!hit_c && !free_c) ? ev_addr : 32'h0;
      way_used       <= 2'(used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SET_DEPTH; s++) begin
        valid[s] <= '0;
      end
    end else if (cmd.commit) begin
      valid[set_idx][used] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/set_assoc_cache_tag_controller_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit
// Tag controller for a set-associative write-back cache with age-counter
// replacement.
// ----------------------------------------------------------------------------
// For each access word, the accept cycle reads the set's tag row from the
// single row RAM, and the lookup state compares all ways, picks the hit, free
// or victim way and writes the row back. With one RAM row read and written per
// access, no new word is taken until the write-back; the lookup state waits
// while the previous result is still held in the output register. Line valid
// bits are flip-flops cleared by reset, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] address,
  input  wire logic        is_write,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit,
  output logic             evicted,
  output logic [31:0]      victim_address,
  output logic [1:0]       way_used
);
  import sact_pkg::*;

  sact_cmd_t cmd;

  sact_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sact_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .address        (address),
    .is_write       (is_write),
    .hit            (hit),
    .evicted        (evicted),
    .victim_address (victim_address),
    .way_used       (way_used)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while lookup pending");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction together");

  a_evict_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (victim_address == 32'h0))
    else $error("eviction address without eviction");

endmodule
`default_nettype wire

[sim/sact_lookup_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sact_lookup_checker
// Watches both channels of the cache tag controller. Every accepted access
// word is run through a tag-array predictor to work out the expected hit,
// eviction and way. Every result word is then checked field by field against
// the oldest expectation.
// ----------------------------------------------------------------------------
module sact_lookup_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] address,
  input  wire logic        is_write,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        hit,
  input  wire logic        evicted,
  input  wire logic [31:0] victim_address,
  input  wire logic [1:0]  way_used,
  output int               fail_count,
  output int               pending
);
  import sact_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] victim_addr;
    logic [1:0]  way;
  } lookup_word_t;

  logic [TAG_BITS-1:0] tag_ram   [SET_DEPTH][WAYS];
  logic                valid_ram [SET_DEPTH][WAYS];
  logic                dirty_ram [SET_DEPTH][WAYS];
  logic [WAY_BITS-1:0] age_ram   [SET_DEPTH][WAYS];
  logic [OFF_W-1:0]    offset_ram[SET_DEPTH][WAYS];

  lookup_word_t lookup_q[$];
  lookup_word_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // updates the predicted tag array and returns the result the access makes
  function automatic lookup_word_t cache_lookup(input logic [31:0] addr_in,
                                                input logic wr);
    logic [31:0]         a;
    logic [TAG_BITS-1:0] tg;
    logic [OFF_W-1:0]    off;
    logic [63:0]         rebuilt;
    logic                found;
    logic                cand_dirty;
    int                  st;
    int                  used;
    int                  cand;
    int                  i;
    lookup_word_t        r;
    a     = addr_in & ADDR_MASK;
    tg    = TAG_BITS'(a >> (OFF_BITS + IDX_BITS));
    st    = int'((a >> OFF_BITS) & SET_MASK);
    off   = OFF_W'(a & OFF_MASK);
    r     = '0;
    found = 1'b0;
    used  = 0;
    for (i = 0; i < WAYS; i++) begin
      if (!found && valid_ram[st][i] && tag_ram[st][i] == tg) begin
        found = 1'b1;
        used  = i;
        r.hit = 1'b1;
        if (wr) dirty_ram[st][i] = 1'b1;
      end
    end
    if (!found) begin
      for (i = 0; i < WAYS; i++) begin
        if (!found && !valid_ram[st][i]) begin
          found = 1'b1;
          used  = i;
        end
      end
      if (!found) begin
        // older ways win; once a dirty candidate is held only dirty ways replace it
        cand       = 0;
        cand_dirty = 1'b0;
        for (i = 0; i < WAYS; i++) begin
          if (age_ram[st][cand] <= age_ram[st][i]) begin
            if (!cand_dirty) begin
              cand       = i;
              cand_dirty = dirty_ram[st][i];
            end else if (dirty_ram[st][i]) begin
              cand = i;
            end
          end
        end
        used      = cand;
        r.evicted = 1'b1;
        rebuilt   = (64'(tag_ram[st][used]) << (IDX_BITS + OFF_BITS))
                  | (64'(st) << OFF_BITS) | 64'(offset_ram[st][used]);
        r.victim_addr = 32'(rebuilt) & ADDR_MASK;
      end
      tag_ram[st][used]    = tg;
      valid_ram[st][used]  = 1'b1;
      dirty_ram[st][used]  = wr;
      offset_ram[st][used] = off;
    end
    if (WAYS > 1) begin
      for (i = 0; i < WAYS; i++) begin
        if (i == used) age_ram[st][i] = '0;
        else if (age_ram[st][i] < AGE_MAX) age_ram[st][i] = age_ram[st][i] + WAY_BITS'(1);
      end
    end
    r.way = 2'(used);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SET_DEPTH; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          tag_ram[s][w]    = '0;
          valid_ram[s][w]  = 1'b0;
          dirty_ram[s][w]  = 1'b0;
          age_ram[s][w]    = '0;
          offset_ram[s][w] = '0;
        end
      end
      lookup_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = lookup_q.pop_front();
          if (hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
          if (evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, want %b", evicted, want.evicted));
          if (victim_address !== want.victim_addr)
            report_mismatch($sformatf("victim_address %h, want %h",
                                      victim_address, want.victim_addr));
          if (way_used !== want.way)
            report_mismatch($sformatf("way_used %0d, want %0d", way_used, want.way));
        end
      end
      if (in_valid && in_ready) lookup_q.push_back(cache_lookup(address, is_write));
    end
    pending = lookup_q.size();
  end

endmodule
`default_nettype wire

[sim/set_assoc_cache_tag_controller_unit_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_unit_test
// Drives access words into the cache tag controller: a directed run over
// fills, hits, write hits and evictions, then random traffic mostly folded onto
// four hot sets and an eight-tag pool so that sets fill and lines are evicted.
// Both sides idle in random bursts. One long output hold-off backs the block
// up. The checker alongside does all the prediction and comparison.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller_unit_test;
  import sact_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] address = '0;
  logic        is_write = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic        evicted;
  logic [31:0] victim_address;
  logic [1:0]  way_used;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit idle_on = 1'b0;
  bit stall_on = 1'b0;
  bit hold_req = 1'b0;

  logic [TAG_BITS-1:0] tag_pool[8];
  int                  hot_set[4];

  set_assoc_cache_tag_controller_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .is_write       (is_write),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .evicted        (evicted),
    .victim_address (victim_address),
    .way_used       (way_used)
  );

  sact_lookup_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .is_write       (is_write),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .evicted        (evicted),
    .victim_address (victim_address),
    .way_used       (way_used),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] mk_addr(input logic [TAG_BITS-1:0] t, input int s,
                                          input int o);
    return (32'(t) << (IDX_BITS + OFF_BITS)) | (32'(s) << OFF_BITS) | 32'(o);
  endfunction

  // offers one access word and returns at the falling edge after it is taken
  task automatic send_word(input logic [31:0] a, input logic wr);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    address  = a;
    is_write = wr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (burst > 0) begin
        out_ready = 1'b0;
        burst--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        burst     = $urandom_range(0, 6);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    int          pick;
    logic [31:0] a;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (tag_pool[k]) tag_pool[k] = TAG_BITS'($urandom);
    foreach (hot_set[k]) hot_set[k] = $urandom_range(0, SET_DEPTH - 1);
    tag_pool[0] = '0;
    tag_pool[1] = '1;

    // directed: extremes, write hit, set fill, evictions of clean and dirty lines
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    for (int k = 1; k <= 4; k++) send_word(mk_addr(TAG_BITS'(k), 5, k * 9), k[0]);
    send_word(mk_addr(TAG_BITS'(2), 5, 0), 1'b1);
    send_word(mk_addr(TAG_BITS'(5), 5, int'(OFF_MASK)), 1'b0);
    send_word(mk_addr(TAG_BITS'(6), 5, 1), 1'b1);
    send_word(mk_addr(TAG_BITS'(1), 5, 2), 1'b0);
    send_word(mk_addr(TAG_BITS'(7), 5, 3), 1'b0);
    send_word(mk_addr(TAG_BITS'(8), 5, 4), 1'b1);
    send_word(mk_addr(TAG_BITS'(2), 5, 5), 1'b0);
    for (int k = 1; k <= 3; k++)
      send_word(mk_addr(TAG_BITS'(-1 - k), SET_DEPTH - 1, k), 1'b0);
    send_word(mk_addr(TAG_BITS'(1), SET_DEPTH - 1, 0), 1'b1);
    send_word(mk_addr(TAG_BITS'(2), SET_DEPTH - 1, int'(OFF_MASK)), 1'b0);
    send_word(32'hFFFF_FFC0, 1'b0);
    send_word(mk_addr(TAG_BITS'(3), SET_DEPTH - 1, 7), 1'b1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on  = (n < 1400) && ((n / 150) % 3 != 2);
      stall_on = (n < 1400) && ((n / 100) % 4 != 3);
      if (n == 500) hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 7)
        a = mk_addr(tag_pool[$urandom_range(0, 5)], hot_set[$urandom_range(0, 3)],
                    $urandom_range(0, int'(OFF_MASK)));
      else if (pick < 9)
        a = mk_addr(tag_pool[$urandom_range(0, 7)], $urandom_range(0, SET_DEPTH - 1),
                    $urandom_range(0, int'(OFF_MASK)));
      else
        a = $urandom;
      send_word(a, 1'($urandom_range(0, 1)));
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
